@@ rtl/mpfb_pkg.sv @@
// Shared types and constants for the monochrome page framebuffer engine.
package mpfb_pkg;

   localparam int unsigned PAGE_ROWS = 8;

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_DRAW   = 3'd1,
      OP_FLIP   = 3'd2,
      OP_FILL   = 3'd3,
      OP_SCROLL = 3'd4,
      OP_READ   = 3'd5,
      OP_RSVD6  = 3'd6,
      OP_RSVD7  = 3'd7
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WIPE,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_SCR_RD,
      ST_SCR_WAIT,
      ST_SCR_WR,
      ST_READ,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture the request transaction
      logic wipe_start;  // reset sweep address
      logic wipe_wr;     // write zero at sweep address, advance
      logic pix_rd;      // read byte at pixel address
      logic pix_wr;      // write modified pixel byte
      logic fill_start;  // reset rectangle counters
      logic fill_rd;     // read byte at rectangle pixel
      logic fill_wr;     // write rectangle pixel, advance counters
      logic scr_start;   // reset scroll counters
      logic scr_rd;      // read source byte(s) for current destination byte
      logic scr_wr;      // write destination byte, advance
      logic rd_issue;    // read byte for the read operation
      logic rd_capture;  // latch read data into the result
      logic clr_result;  // result is zero
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      logic   wipe_last;
      logic   scroll_wipe;
      logic   fill_empty;
      logic   fill_last;
      logic   scr_last;
      logic   scr_second;  // current destination needs a second source byte
      logic   scr_phase;   // 0: first source read, 1: second
   } stat_type;

endpackage

@@ rtl/mono_page_framebuffer_engine_top.sv @@
// Top level of the monochrome page-organized framebuffer engine.
//   channel | direction | tdata fields (low bit up)
//   req     | in        | operation, x_coord, y_coord, rect_width, rect_height,
//           |           | pixel_on, scroll_offset, byte_address (55 bits, 56 wide)
//   rsp     | out       | read_data (8 bits)
// Draw and flip read and rewrite one store byte, read reads one, fill does so per pixel.
// Clear zeroes the store; scroll shifts in one or two source bytes per byte, or clears.
// After reset a sweep zeroes all WIDTH*ceil(HEIGHT/8) store bytes while req_tready is low.
// One transaction is in work at a time; the result waits in a register for rsp_tready.
module mono_page_framebuffer_engine_top #(
   parameter int unsigned WIDTH  = 128,
   parameter int unsigned HEIGHT = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // operation, x_coord, y_coord, rect_width,
                                    // rect_height, pixel_on, scroll_offset, byte_address
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // read_data
);

   mpfb_pkg::cmd_type  cmd;
   mpfb_pkg::stat_type stat;

   mpfb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mpfb_datapath #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .stat     (stat),
      .op_in    (req_tdata[2:0]),
      .x_in     (req_tdata[10:3]),
      .y_in     (req_tdata[18:11]),
      .w_in     (req_tdata[26:19]),
      .h_in     (req_tdata[34:27]),
      .on_in    (req_tdata[35]),
      .offset_in(req_tdata[43:36]),
      .addr_in  (req_tdata[54:44]),
      .read_data(rsp_tdata)
   );

endmodule

@@ rtl/mpfb_ram.sv @@
// Generic single-port RAM with registered read data.
module mpfb_ram #(
   parameter int unsigned DATA_W = 8,
   parameter int unsigned DEPTH  = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [DATA_W-1:0]        wr_data,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/mpfb_ctrl.sv @@
// Controller state machine sequencing every framebuffer operation.
module mpfb_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  mpfb_pkg::stat_type   stat,
   output mpfb_pkg::cmd_type    cmd
);

   mpfb_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpfb_pkg::ST_WIPE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign req_tready = (state_ff == mpfb_pkg::ST_IDLE) && !rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         mpfb_pkg::ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load = 1'b1;
               state_in = mpfb_pkg::ST_RESP;
            end
         end
         mpfb_pkg::ST_RESP: begin
            cmd.clr_result = 1'b1;
            unique case (stat.op)
               mpfb_pkg::OP_CLEAR: begin
                  cmd.wipe_start = 1'b1;
                  state_in = mpfb_pkg::ST_WIPE;
               end
               mpfb_pkg::OP_DRAW, mpfb_pkg::OP_FLIP: state_in = mpfb_pkg::ST_PIX_RD;
               mpfb_pkg::OP_FILL: begin
                  cmd.fill_start = 1'b1;
                  state_in = mpfb_pkg::ST_FILL_RD;
               end
               mpfb_pkg::OP_SCROLL: begin
                  cmd.wipe_start = 1'b1;
                  cmd.scr_start  = 1'b1;
                  state_in = stat.scroll_wipe ? mpfb_pkg::ST_WIPE : mpfb_pkg::ST_SCR_RD;
               end
               mpfb_pkg::OP_READ: begin
                  cmd.rd_issue = 1'b1;
                  state_in = mpfb_pkg::ST_READ;
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  state_in = mpfb_pkg::ST_IDLE;
               end
            endcase
         end
         mpfb_pkg::ST_WIPE: begin
            cmd.wipe_wr = 1'b1;
            if (stat.wipe_last) begin
               state_in = mpfb_pkg::ST_IDLE;
               rsp_valid_in = (stat.op == mpfb_pkg::OP_CLEAR)
                  || (stat.op == mpfb_pkg::OP_SCROLL);
            end
         end
         mpfb_pkg::ST_PIX_RD: begin
            cmd.pix_rd = 1'b1;
            state_in = mpfb_pkg::ST_PIX_WR;
         end
         mpfb_pkg::ST_PIX_WR: begin
            cmd.pix_wr = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = mpfb_pkg::ST_IDLE;
         end
         mpfb_pkg::ST_FILL_RD: begin
            if (stat.fill_empty) begin
               rsp_valid_in = 1'b1;
               state_in = mpfb_pkg::ST_IDLE;
            end else begin
               cmd.fill_rd = 1'b1;
               state_in = mpfb_pkg::ST_FILL_WR;
            end
         end
         mpfb_pkg::ST_FILL_WR: begin
            cmd.fill_wr = 1'b1;
            if (stat.fill_last) begin
               rsp_valid_in = 1'b1;
               state_in = mpfb_pkg::ST_IDLE;
            end else begin
               state_in = mpfb_pkg::ST_FILL_RD;
            end
         end
         mpfb_pkg::ST_SCR_RD: begin
            cmd.scr_rd = 1'b1;
            state_in = mpfb_pkg::ST_SCR_WAIT;
         end
         mpfb_pkg::ST_SCR_WAIT: begin
            if (stat.scr_second && !stat.scr_phase) begin
               state_in = mpfb_pkg::ST_SCR_RD;
            end else begin
               state_in = mpfb_pkg::ST_SCR_WR;
            end
         end
         mpfb_pkg::ST_SCR_WR: begin
            cmd.scr_wr = 1'b1;
            if (stat.scr_last) begin
               rsp_valid_in = 1'b1;
               state_in = mpfb_pkg::ST_IDLE;
            end else begin
               state_in = mpfb_pkg::ST_SCR_RD;
            end
         end
         mpfb_pkg::ST_READ: begin
            cmd.rd_capture = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = mpfb_pkg::ST_IDLE;
         end
         default: state_in = mpfb_pkg::ST_IDLE;
      endcase
   end

endmodule

@@ rtl/mpfb_datapath.sv @@
// Datapath: request registers, address generation, byte merge and the frame store.
module mpfb_datapath #(
   parameter int unsigned WIDTH  = 128,
   parameter int unsigned HEIGHT = 128
) (
   input  logic                clock,
   input  logic                reset,
   input  mpfb_pkg::cmd_type   cmd,
   output mpfb_pkg::stat_type  stat,
   input  logic [2:0]          op_in,
   input  logic [7:0]          x_in,
   input  logic [7:0]          y_in,
   input  logic [7:0]          w_in,
   input  logic [7:0]          h_in,
   input  logic                on_in,
   input  logic [7:0]          offset_in,
   input  logic [10:0]         addr_in,
   output logic [7:0]          read_data
);

   localparam int unsigned PAGES   = (HEIGHT + mpfb_pkg::PAGE_ROWS - 1) / mpfb_pkg::PAGE_ROWS;
   localparam int unsigned BYTES   = WIDTH * PAGES;
   localparam int unsigned AW      = $clog2(BYTES);
   localparam int unsigned PW      = (PAGES > 1) ? $clog2(PAGES) : 1;

   mpfb_pkg::op_type op_ff;
   logic [7:0]  x_ff, y_ff, w_ff, h_ff, off_ff;
   logic        on_ff;
   logic [10:0] addr_ff;
   logic [7:0]  result_ff;

   logic [AW-1:0] wipe_ff;
   logic [7:0]    fi_ff, fj_ff;
   logic [7:0]    sx_ff;
   logic [PW-1:0] sp_ff;
   logic          sph_ff;
   logic [7:0]    s0_ff;
   logic [7:0]    s1_ff;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [7:0]    ram_wd, ram_rd;

   mpfb_ram #(.DATA_W(8), .DEPTH(BYTES)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wd),
      .rd_data(ram_rd)
   );

   // Pixel under work: single pixel or current rectangle pixel.
   logic [7:0] px, py;
   logic       pvalid;
   logic [AW-1:0] paddr;
   logic [7:0]    pmask;
   logic [7:0]    merged;

   always_comb begin
      if (op_ff == mpfb_pkg::OP_FILL) begin
         px = x_ff + fi_ff;
         py = y_ff + fj_ff;
      end else begin
         px = x_ff;
         py = y_ff;
      end
      pvalid = ({1'b0, px} < 9'(WIDTH)) && ({1'b0, py} < 9'(HEIGHT));
      paddr  = AW'(AW'(px) + AW'(py[7:3]) * AW'(WIDTH));
      pmask  = 8'(1) << py[2:0];
      if (op_ff == mpfb_pkg::OP_FLIP) begin
         merged = ram_rd ^ pmask;
      end else if (on_ff) begin
         merged = ram_rd | pmask;
      end else begin
         merged = ram_rd & ~pmask;
      end
   end

   // Scroll: destination page sp at column sx takes rows 8*sp+off .. +7.
   logic [8:0]    src_row;
   logic [5:0]    src_page0;
   logic [2:0]    sh;
   logic          second;
   logic [AW-1:0] src_addr;
   logic [15:0]   pair;
   logic [7:0]    shifted, rowmask, scr_byte;
   logic [8:0]    dst_row0;

   always_comb begin
      dst_row0  = 9'({sp_ff, 3'b000});
      src_row   = dst_row0 + 9'(off_ff);
      src_page0 = src_row[8:3];
      sh        = src_row[2:0];
      second    = (sh != 3'd0) && ({src_page0 + 6'd1, 3'b000} < 9'(HEIGHT));
      src_addr  = AW'(AW'(sx_ff) + AW'(src_page0 + 6'(sph_ff)) * AW'(WIDTH));
      pair      = {(second ? s1_ff : 8'h00), s0_ff};
      shifted   = 8'(pair >> sh);
      for (int b = 0; b < 8; b++) begin
         rowmask[b] = (src_row + 9'(b)) < 9'(HEIGHT);
      end
      if ({src_page0, 3'b000} >= 9'(HEIGHT)) begin
         scr_byte = 8'h00;
      end else begin
         scr_byte = shifted & rowmask;
      end
   end

   logic fill_last_i, fill_last_j;
   assign fill_last_i = (fi_ff == w_ff - 8'd1);
   assign fill_last_j = (fj_ff == h_ff - 8'd1);

   always_comb begin
      ram_we   = 1'b0;
      ram_addr = paddr;
      ram_wd   = merged;
      if (cmd.wipe_wr) begin
         ram_we   = 1'b1;
         ram_addr = wipe_ff;
         ram_wd   = 8'h00;
      end else if (cmd.pix_wr || cmd.fill_wr) begin
         ram_we   = pvalid;
      end else if (cmd.scr_rd) begin
         ram_addr = src_addr;
      end else if (cmd.scr_wr) begin
         ram_we   = 1'b1;
         ram_addr = AW'(AW'(sx_ff) + AW'(sp_ff) * AW'(WIDTH));
         ram_wd   = scr_byte;
      end else if (cmd.rd_issue) begin
         ram_addr = AW'(addr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= mpfb_pkg::OP_READ;
      end else if (cmd.load) begin
         op_ff <= mpfb_pkg::op_type'(op_in);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         w_ff    <= w_in;
         h_ff    <= h_in;
         on_ff   <= on_in;
         off_ff  <= offset_in;
         addr_ff <= addr_in;
      end
      if (cmd.clr_result) begin
         result_ff <= 8'h00;
      end else if (cmd.rd_capture) begin
         result_ff <= ({1'b0, addr_ff} < 12'(BYTES)) ? ram_rd : 8'h00;
      end
      if (cmd.fill_start) begin
         fi_ff <= 8'd0;
         fj_ff <= 8'd0;
      end else if (cmd.fill_wr) begin
         if (fill_last_j) begin
            fj_ff <= 8'd0;
            fi_ff <= fi_ff + 8'd1;
         end else begin
            fj_ff <= fj_ff + 8'd1;
         end
      end
      if (cmd.scr_start) begin
         sx_ff  <= 8'd0;
         sp_ff  <= '0;
         sph_ff <= 1'b0;
      end else if (cmd.scr_wr) begin
         sph_ff <= 1'b0;
         if (sp_ff == PW'(PAGES - 1)) begin
            sp_ff <= '0;
            sx_ff <= sx_ff + 8'd1;
         end else begin
            sp_ff <= sp_ff + PW'(1);
         end
      end else if (cmd == '0) begin
         if (!sph_ff) begin
            s0_ff <= ram_rd;
            if (second) begin
               sph_ff <= 1'b1;
            end
         end else begin
            s1_ff <= ram_rd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.wipe_start) begin
         wipe_ff <= '0;
      end else if (cmd.wipe_wr) begin
         wipe_ff <= wipe_ff + AW'(1);
      end
   end

   always_comb begin
      stat.op          = op_ff;
      stat.wipe_last   = (wipe_ff == AW'(BYTES - 1));
      stat.scroll_wipe = (off_ff == 8'd0) || ({1'b0, off_ff} >= 9'(HEIGHT));
      stat.fill_empty  = (w_ff == 8'd0) || (h_ff == 8'd0);
      stat.fill_last   = fill_last_i && fill_last_j;
      stat.scr_last    = (sx_ff == 8'(WIDTH - 1)) && (sp_ff == PW'(PAGES - 1));
      stat.scr_second  = second;
      stat.scr_phase   = sph_ff;
   end

   assign read_data = result_ff;

endmodule

@@ rtl/mpfb_checker.sv @@
// Port-level checker for the framebuffer engine, bound to the top level.
module mpfb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   a_no_accept_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken while result pending");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   a_no_ready_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("ready right after accept");

   a_no_rsp_in_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid) else $error("result during reset");

endmodule

bind mono_page_framebuffer_engine_top mpfb_checker u_mpfb_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
